// ----- src/ufsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unit fraction sum reducer package
// Shared widths, status and operation codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ufsr_pkg;

    localparam int SUM_WIDTH_DEF  = 32;
    localparam int TERM_WIDTH_DEF = 16;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int OPW = 4;
    typedef logic [OPW-1:0] op_t;

    localparam op_t OP_GCD_MD   = 4'd0;
    localparam op_t OP_DIV_MG   = 4'd1;
    localparam op_t OP_DIV_DG   = 4'd2;
    localparam op_t OP_MUL_NDR  = 4'd3;
    localparam op_t OP_ADD_MR   = 4'd4;
    localparam op_t OP_DIV_NUMG = 4'd5;
    localparam op_t OP_GCD_RG   = 4'd6;
    localparam op_t OP_DIV_NUMH = 4'd7;
    localparam op_t OP_DIV_DH   = 4'd8;
    localparam op_t OP_MUL_MRE  = 4'd9;

    typedef struct packed {
        logic load_in;
        logic start;
        op_t  op;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic done;
        logic last;
        logic out_free;
    } sts_t;

    function automatic op_t next_op(input op_t op);
        op_t nxt;
        case (op)
            OP_GCD_MD:   nxt = OP_DIV_MG;
            OP_DIV_MG:   nxt = OP_DIV_DG;
            OP_DIV_DG:   nxt = OP_MUL_NDR;
            OP_MUL_NDR:  nxt = OP_ADD_MR;
            OP_ADD_MR:   nxt = OP_DIV_NUMG;
            OP_DIV_NUMG: nxt = OP_GCD_RG;
            OP_GCD_RG:   nxt = OP_DIV_NUMH;
            OP_DIV_NUMH: nxt = OP_DIV_DH;
            OP_DIV_DH:   nxt = OP_MUL_MRE;
            default:     nxt = OP_GCD_MD;
        endcase
        return nxt;
    endfunction

endpackage
`default_nettype wire

// ----- src/ufsr_term_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Term channel
// Valid/ready channel carrying one unit fraction denominator per beat.
// ----------------------------------------------------------------------------
interface ufsr_term_if #(
    parameter int TERM_WIDTH = ufsr_pkg::TERM_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [TERM_WIDTH-1:0] unit_denominator;
    logic                  last_term;

    modport source (output valid, output unit_denominator, output last_term, input ready);
    modport sink   (input valid, input unit_denominator, input last_term, output ready);
endinterface
`default_nettype wire

// ----- src/ufsr_sum_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sum channel
// Valid/ready channel carrying one reduced sum and its status per beat.
// ----------------------------------------------------------------------------
interface ufsr_sum_if #(
    parameter int SUM_WIDTH = ufsr_pkg::SUM_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [SUM_WIDTH-1:0] sum_numerator;
    logic [SUM_WIDTH-1:0] sum_denominator;
    logic [1:0]           status;

    modport source (output valid, output sum_numerator, output sum_denominator,
                    output status, input ready);
    modport sink   (input valid, input sum_numerator, input sum_denominator,
                    input status, output ready);
endinterface
`default_nettype wire

// ----- src/ufsr_gcd.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary GCD unit
// One halving or subtract-and-halve step per cycle; pulses done when the
// greatest common divisor is ready on result.
// ----------------------------------------------------------------------------
module ufsr_gcd #(
    parameter int W = ufsr_pkg::SUM_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              done,
    output logic [W-1:0]      result
);
    localparam int KW = $clog2(W + 1);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  res_reg, res_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0)
            begin
                res_next  = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                res_next  = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ----- src/ufsr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle over the full dividend width; pulses done when
// quotient and remainder are ready.
// ----------------------------------------------------------------------------
module ufsr_div #(
    parameter int NW = 49,
    parameter int VW = ufsr_pkg::TERM_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quotient,
    output logic [VW-1:0]      remainder
);
    localparam int CW = $clog2(NW);

    logic [NW-1:0] q_reg, q_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] v_reg, v_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial     = {r_reg, q_reg[NW-1]};
        diff      = trial - {1'b0, v_reg};
        ge        = trial >= {1'b0, v_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        v_next    = v_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            v_next    = divisor;
            cnt_next  = CW'(NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next = ge ? diff[VW-1:0] : trial[VW-1:0];
            q_next = {q_reg[NW-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        v_reg   <= v_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < v_reg))
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// ----- src/ufsr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unit fraction sum reducer controller
// Accepts a term; unless it is zero or the sum is in error, it steps the
// datapath through its operations and commits; emits the result on last term.
// ----------------------------------------------------------------------------
module ufsr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ufsr_pkg::sts_t  sts,
    output ufsr_pkg::cmd_t       cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]         state_reg, state_next;
    ufsr_pkg::op_t      op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (sts.go)
                    begin
                        op_next    = ufsr_pkg::OP_GCD_MD;
                        state_next = S_LAUNCH;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_LAUNCH:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.done)
                begin
                    if (op_reg == ufsr_pkg::OP_MUL_MRE)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        op_next    = ufsr_pkg::next_op(op_reg);
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.last)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ufsr_pkg::OP_GCD_MD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/ufsr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unit fraction sum reducer datapath
// Holds the running sum, the term and the intermediate values, runs the GCD
// unit, the divider and a shift-add multiplier, and owns the result register.
// ----------------------------------------------------------------------------
module ufsr_dp #(
    parameter int SUM_WIDTH  = ufsr_pkg::SUM_WIDTH_DEF,
    parameter int TERM_WIDTH = ufsr_pkg::TERM_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ufsr_pkg::cmd_t        cmd,
    output ufsr_pkg::sts_t             sts,
    input  wire logic [TERM_WIDTH-1:0] unit_denominator,
    input  wire logic                  last_term,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [SUM_WIDTH-1:0]       sum_numerator,
    output logic [SUM_WIDTH-1:0]       sum_denominator,
    output logic [1:0]                 status
);
    localparam int SW  = SUM_WIDTH;
    localparam int TW  = TERM_WIDTH;
    localparam int GW  = (SW > TW) ? SW : TW;
    localparam int PW  = SW + TW;
    localparam int DW  = SW + TW + 1;
    localparam int MCW = $clog2(TW);

    logic [SW-1:0]  n_reg;
    logic [SW-1:0]  m_reg;
    logic [1:0]     st_reg;
    logic [TW-1:0]  d_reg;
    logic           last_reg;
    ufsr_pkg::op_t  op_reg;
    logic [TW-1:0]  g_reg;
    logic [SW-1:0]  mr_reg;
    logic [TW-1:0]  dr_reg;
    logic [DW-1:0]  num_reg;
    logic [TW-1:0]  r_reg;
    logic [TW-1:0]  h_reg;
    logic [DW-1:0]  q_reg;
    logic [TW-1:0]  e_reg;
    logic [PW-1:0]  den_reg;
    logic           add_done_reg;
    logic           out_valid_reg;
    logic [SW-1:0]  out_n_reg;
    logic [SW-1:0]  out_m_reg;
    logic [1:0]     out_st_reg;

    logic [SW-1:0]  mul_a_reg;
    logic [TW-1:0]  mul_b_reg;
    logic [PW-1:0]  mul_acc_reg;
    logic [MCW-1:0] mul_cnt_reg;
    logic           mul_busy_reg;
    logic           mul_done_reg;

    logic           gcd_start;
    logic [GW-1:0]  gcd_a;
    logic [GW-1:0]  gcd_b;
    logic           gcd_done;
    logic [GW-1:0]  gcd_res;

    logic           div_start;
    logic [DW-1:0]  div_n;
    logic [TW-1:0]  div_v;
    logic           div_done;
    logic [DW-1:0]  div_q;
    logic [TW-1:0]  div_r;

    logic           mul_start;
    logic           add_start;
    logic           ovf;
    logic           out_free;

    always_comb
    begin
        gcd_start = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        add_start = 1'b0;
        gcd_a     = GW'(m_reg);
        gcd_b     = GW'(d_reg);
        div_n     = num_reg;
        div_v     = g_reg;
        case (cmd.op)
            ufsr_pkg::OP_GCD_MD:
            begin
                gcd_start = cmd.start;
            end
            ufsr_pkg::OP_GCD_RG:
            begin
                gcd_start = cmd.start;
                gcd_a     = GW'(r_reg);
                gcd_b     = GW'(g_reg);
            end
            ufsr_pkg::OP_DIV_MG:
            begin
                div_start = cmd.start;
                div_n     = DW'(m_reg);
            end
            ufsr_pkg::OP_DIV_DG:
            begin
                div_start = cmd.start;
                div_n     = DW'(d_reg);
            end
            ufsr_pkg::OP_DIV_NUMG:
            begin
                div_start = cmd.start;
            end
            ufsr_pkg::OP_DIV_NUMH:
            begin
                div_start = cmd.start;
                div_v     = h_reg;
            end
            ufsr_pkg::OP_DIV_DH:
            begin
                div_start = cmd.start;
                div_n     = DW'(d_reg);
                div_v     = h_reg;
            end
            ufsr_pkg::OP_MUL_NDR,
            ufsr_pkg::OP_MUL_MRE:
            begin
                mul_start = cmd.start;
            end
            ufsr_pkg::OP_ADD_MR:
            begin
                add_start = cmd.start;
            end
            default:
            begin
                gcd_start = 1'b0;
            end
        endcase
    end

    ufsr_gcd #(
        .W (GW)
    ) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .a      (gcd_a),
        .b      (gcd_b),
        .done   (gcd_done),
        .result (gcd_res)
    );

    ufsr_div #(
        .NW (DW),
        .VW (TW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_v),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // shift-add multiplier, multiplier bits taken MSB first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            add_done_reg <= 1'b0;
        end
        else
        begin
            mul_done_reg <= mul_busy_reg && (mul_cnt_reg == '0);
            add_done_reg <= add_start;
            if (mul_start)
            begin
                mul_busy_reg <= 1'b1;
            end
            else if (mul_busy_reg && (mul_cnt_reg == '0))
            begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mul_a_reg   <= (cmd.op == ufsr_pkg::OP_MUL_NDR) ? n_reg : mr_reg;
            mul_b_reg   <= (cmd.op == ufsr_pkg::OP_MUL_NDR) ? dr_reg : e_reg;
            mul_acc_reg <= '0;
            mul_cnt_reg <= MCW'(TW - 1);
        end
        else if (mul_busy_reg)
        begin
            mul_acc_reg <= (mul_acc_reg << 1)
                         + (mul_b_reg[TW-1] ? PW'(mul_a_reg) : PW'(0));
            mul_b_reg   <= mul_b_reg << 1;
            mul_cnt_reg <= mul_cnt_reg - MCW'(1);
        end
    end

    // capture unit results into the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= cmd.op;
        end
        if (cmd.load_in)
        begin
            d_reg    <= unit_denominator;
            last_reg <= last_term;
        end
        if (gcd_done)
        begin
            if (op_reg == ufsr_pkg::OP_GCD_MD)
            begin
                g_reg <= gcd_res[TW-1:0];
            end
            else
            begin
                h_reg <= gcd_res[TW-1:0];
            end
        end
        if (div_done)
        begin
            case (op_reg)
                ufsr_pkg::OP_DIV_MG:   mr_reg <= div_q[SW-1:0];
                ufsr_pkg::OP_DIV_DG:   dr_reg <= div_q[TW-1:0];
                ufsr_pkg::OP_DIV_NUMG: r_reg  <= div_r;
                ufsr_pkg::OP_DIV_NUMH: q_reg  <= div_q;
                ufsr_pkg::OP_DIV_DH:   e_reg  <= div_q[TW-1:0];
                default:               e_reg  <= e_reg;
            endcase
        end
        if (mul_done_reg)
        begin
            if (op_reg == ufsr_pkg::OP_MUL_NDR)
            begin
                num_reg <= DW'(mul_acc_reg);
            end
            else
            begin
                den_reg <= mul_acc_reg;
            end
        end
        else if (add_done_reg)
        begin
            num_reg <= num_reg + DW'(mr_reg);
        end
    end

    assign ovf      = (|q_reg[DW-1:SW]) || (|den_reg[PW-1:SW]);
    assign out_free = !out_valid_reg || out_ready;

    // running sum and sticky status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            m_reg         <= SW'(1);
            st_reg        <= ufsr_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                n_reg  <= '0;
                m_reg  <= SW'(1);
                st_reg <= ufsr_pkg::ST_OK;
            end
            else if (cmd.commit)
            begin
                if (ovf)
                begin
                    st_reg <= ufsr_pkg::ST_OVF;
                end
                else
                begin
                    n_reg <= q_reg[SW-1:0];
                    m_reg <= den_reg[SW-1:0];
                end
            end
            else if (cmd.load_in && (st_reg == ufsr_pkg::ST_OK)
                     && (unit_denominator == '0))
            begin
                st_reg <= ufsr_pkg::ST_ZERO;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_n_reg  <= n_reg;
            out_m_reg  <= m_reg;
            out_st_reg <= st_reg;
        end
    end

    always_comb
    begin
        sts          = '0;
        sts.go       = (st_reg == ufsr_pkg::ST_OK) && (unit_denominator != '0);
        sts.done     = gcd_done || div_done || mul_done_reg || add_done_reg;
        sts.last     = last_reg;
        sts.out_free = out_free;
    end

    assign out_valid       = out_valid_reg;
    assign sum_numerator   = out_n_reg;
    assign sum_denominator = out_m_reg;
    assign status          = out_st_reg;

    a_emit_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && (n_reg == '0) && (m_reg == SW'(1))
                      && (st_reg == ufsr_pkg::ST_OK)))
        else $error("sum not cleared after result beat");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_done |-> (gcd_res != '0))
        else $error("gcd result is zero");

    a_commit_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !ovf) |=> (m_reg != '0))
        else $error("committed denominator is zero");

endmodule
`default_nettype wire

// ----- src/unit_fraction_sum_reducer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unit fraction sum reducer
// Adds unit fractions 1/d into a running sum kept in lowest terms and returns
// the reduced sum with a status code at the end of each set.
//
// terms: one beat per denominator; last_term closes the set.
// sums:  one beat per set with numerator, denominator and status
//        (ok, zero denominator seen, overflow). After a beat the sum is 0/1.
// A term with a zero denominator, or any term after an error, skips the arithmetic.
// A term that is added runs the full operation sequence; the five passes
// of the one-bit-per-cycle divider and the two binary GCD runs take most
// of its time.
// One term is in flight at a time; terms.ready is high only between terms.
// The result sits in an output register, so the next set starts while it
// waits; when the receiver stalls, the next last term waits for that register.
// Reset clears the sum to 0/1 with status ok and drops any pending result.
// ----------------------------------------------------------------------------
module unit_fraction_sum_reducer #(
    parameter int SUM_WIDTH  = ufsr_pkg::SUM_WIDTH_DEF,
    parameter int TERM_WIDTH = ufsr_pkg::TERM_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ufsr_term_if.sink  terms,
    ufsr_sum_if.source sums
);
    ufsr_pkg::cmd_t       cmd;
    ufsr_pkg::sts_t       sts;
    logic                 in_ready;
    logic                 out_valid;
    logic [SUM_WIDTH-1:0] out_num;
    logic [SUM_WIDTH-1:0] out_den;
    logic [1:0]           out_st;

    ufsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (terms.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ufsr_dp #(
        .SUM_WIDTH  (SUM_WIDTH),
        .TERM_WIDTH (TERM_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .unit_denominator (terms.unit_denominator),
        .last_term        (terms.last_term),
        .out_ready        (sums.ready),
        .out_valid        (out_valid),
        .sum_numerator    (out_num),
        .sum_denominator  (out_den),
        .status           (out_st)
    );

    assign terms.ready          = in_ready;
    assign sums.valid           = out_valid;
    assign sums.sum_numerator   = out_num;
    assign sums.sum_denominator = out_den;
    assign sums.status          = out_st;

endmodule
`default_nettype wire
